FILE: rtl/core/hufdec_pkg.sv
// Shared types and codes for the Huffman table load and decode block.
// No dependencies; used by huffman_table_load_and_decode_top.
package hufdec_pkg;

   // Default sizing of the node table and the longest accepted codeword
   localparam int MAX_CODE_LEN_DEF = 32;
   localparam int NODE_COUNT_DEF   = 256;

   // Fixed field widths
   localparam int SYM_W      = 7;
   localparam int LEN_W      = 6;
   localparam int CODE_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int NBITS_W    = 4;
   localparam int BYTE_BITS  = 8;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 8;

   // Command codes carried in req_tuser
   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_DECODE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Result status codes carried in rsp_tuser
   typedef enum logic [1:0] {
      STS_SYMBOL  = 2'd0,
      STS_MISSING = 2'd1,
      STS_BADCODE = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_EV,
      ST_DEC_RD,
      ST_DEC_EV,
      ST_FLUSH
   } state_type;

endpackage

FILE: rtl/core/huffman_table_load_and_decode_top.sv
// Huffman table load and decode: node table memory plus one walk sequencer.
// Depends on hufdec_pkg for codes, widths and default parameters.
//
// One transaction is taken at a time; req_tready is high only while the sequencer is idle.
// Every step goes through the single read port of the node table, whose read data is
// registered, so the rate is set by that port. Clear rewrites an empty root entry and resets
// the allocation count. A code entry reads and evaluates the node for each branch that already
// exists and allocates and writes each new branch without a read, then stores the symbol; a
// rejected entry ends in the flush state instead. A data byte walks one node per valid bit
// from where the last byte stopped, back to the root after each result, and waits while
// rsp_tready stays low. Results of one transaction leave in order; the last has rsp_tlast
// set, so each result waits one step in a holding register. Reset first writes an empty root.
module huffman_table_load_and_decode_top #(
   parameter int MAX_CODE_LEN = hufdec_pkg::MAX_CODE_LEN_DEF,
   parameter int NODE_COUNT   = hufdec_pkg::NODE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // symbol[6:0], code_len[12:7], code_bits[44:13], data_byte[52:45], valid_bits[56:53]
   input  logic [hufdec_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // decoded_symbol[6:0]
   output logic [hufdec_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int IW    = $clog2(NODE_COUNT);
   localparam int EW    = 2 * IW + hufdec_pkg::SYM_W;
   localparam int LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

   // Entry layout: sym in the low bits, then right child, then left child
   localparam int SYM_LO   = 0;
   localparam int RIGHT_LO = hufdec_pkg::SYM_W;
   localparam int LEFT_LO  = hufdec_pkg::SYM_W + IW;

   // Input fields
   logic [hufdec_pkg::SYM_W-1:0]   in_symbol;
   logic [hufdec_pkg::LEN_W-1:0]   in_code_len;
   logic [hufdec_pkg::CODE_W-1:0]  in_code_bits;
   logic [hufdec_pkg::BYTE_W-1:0]  in_data_byte;
   logic [hufdec_pkg::NBITS_W-1:0] in_valid_bits;
   hufdec_pkg::cmd_type            in_cmd;

   assign in_symbol     = req_tdata[6:0];
   assign in_code_len   = req_tdata[12:7];
   assign in_code_bits  = req_tdata[44:13];
   assign in_data_byte  = req_tdata[52:45];
   assign in_valid_bits = req_tdata[56:53];
   assign in_cmd        = hufdec_pkg::cmd_type'(req_tuser);

   // Node table
   logic [EW-1:0] mem [NODE_COUNT];
   logic [EW-1:0] rd_data_ff;
   logic          mem_we;
   logic [IW-1:0] mem_wa;
   logic [EW-1:0] mem_wd;
   logic          rd_en;

   // Sequencer state
   hufdec_pkg::state_type            state_ff, state_in;
   logic [IW-1:0]                    cur_ff, cur_in;
   logic [IW-1:0]                    walk_ff, walk_in;
   logic [IW:0]                      next_free_ff, next_free_in;
   logic                             fresh_ff, fresh_in;
   logic                             check_ff, check_in;
   logic [hufdec_pkg::LEN_W-1:0]     cnt_ff, cnt_in;
   logic [hufdec_pkg::CODE_W-1:0]    bits_ff, bits_in;
   logic [hufdec_pkg::SYM_W-1:0]     sym_ff, sym_in;

   // Holding register and output register
   logic                             pend_valid_ff, pend_valid_in;
   hufdec_pkg::status_type           pend_status_ff, pend_status_in;
   logic [hufdec_pkg::SYM_W-1:0]     pend_sym_ff, pend_sym_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   hufdec_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [hufdec_pkg::SYM_W-1:0]     rsp_sym_ff, rsp_sym_in;
   logic                             rsp_last_ff, rsp_last_in;

   // Step working values
   logic [EW-1:0]                    ent;
   logic [IW-1:0]                    ent_left, ent_right, slot;
   logic                             bit_c;
   logic                             out_free;
   logic                             emit, stall;
   hufdec_pkg::status_type           emit_status;
   logic [hufdec_pkg::SYM_W-1:0]     emit_sym;

   assign ent       = fresh_ff ? '0 : rd_data_ff;
   assign ent_left  = ent[LEFT_LO +: IW];
   assign ent_right = ent[RIGHT_LO +: IW];
   assign bit_c     = bits_ff[hufdec_pkg::CODE_W-1];
   assign slot      = bit_c ? ent_right : ent_left;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[cur_ff];
      end
   end

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      walk_in        = walk_ff;
      next_free_in   = next_free_ff;
      fresh_in       = fresh_ff;
      check_in       = check_ff;
      cnt_in         = cnt_ff;
      bits_in        = bits_ff;
      sym_in         = sym_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_sym_in    = pend_sym_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_sym_in     = rsp_sym_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_wa         = cur_ff;
      mem_wd         = ent;
      rd_en          = 1'b0;
      emit           = 1'b0;
      stall          = 1'b0;
      emit_status    = hufdec_pkg::STS_SYMBOL;
      emit_sym       = '0;
      req_tready     = 1'b0;

      unique case (state_ff)
         hufdec_pkg::ST_INIT: begin
            // Empty root, table counts back to start
            mem_we       = 1'b1;
            mem_wa       = '0;
            mem_wd       = '0;
            next_free_in = (IW+1)'(1);
            walk_in      = '0;
            state_in     = hufdec_pkg::ST_IDLE;
         end
         hufdec_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               fresh_in = 1'b0;
               check_in = 1'b0;
               unique case (in_cmd)
                  hufdec_pkg::CMD_CLEAR: begin
                     state_in = hufdec_pkg::ST_INIT;
                  end
                  hufdec_pkg::CMD_ADD: begin
                     if ({1'b0, in_code_len} > 7'(LIMIT)) begin
                        pend_valid_in  = 1'b1;
                        pend_status_in = hufdec_pkg::STS_BADCODE;
                        pend_sym_in    = '0;
                        state_in       = hufdec_pkg::ST_FLUSH;
                     end else begin
                        cur_in   = '0;
                        cnt_in   = in_code_len;
                        sym_in   = in_symbol;
                        // Left-align so the first branch sits in the top bit
                        bits_in  = in_code_bits << (6'd32 - in_code_len);
                        state_in = hufdec_pkg::ST_ADD_RD;
                     end
                  end
                  hufdec_pkg::CMD_DECODE: begin
                     cur_in  = walk_ff;
                     bits_in = {in_data_byte, {(hufdec_pkg::CODE_W-hufdec_pkg::BYTE_W){1'b0}}};
                     if (in_valid_bits > 4'(hufdec_pkg::BYTE_BITS)) begin
                        cnt_in = hufdec_pkg::LEN_W'(hufdec_pkg::BYTE_BITS);
                     end else begin
                        cnt_in = {2'b00, in_valid_bits};
                     end
                     if (in_valid_bits == '0) begin
                        state_in = hufdec_pkg::ST_IDLE;
                     end else begin
                        state_in = hufdec_pkg::ST_DEC_RD;
                     end
                  end
                  hufdec_pkg::CMD_NONE: begin
                     state_in = hufdec_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         hufdec_pkg::ST_ADD_RD: begin
            rd_en    = 1'b1;
            state_in = hufdec_pkg::ST_ADD_EV;
         end
         hufdec_pkg::ST_ADD_EV: begin
            // Write back the current node every step so a new node never keeps stale content
            mem_we = 1'b1;
            if (cnt_ff == '0) begin
               mem_wd[SYM_LO +: hufdec_pkg::SYM_W] = sym_ff;
               state_in = hufdec_pkg::ST_IDLE;
            end else if (slot == '0) begin
               if (next_free_ff == (IW+1)'(NODE_COUNT)) begin
                  pend_valid_in  = 1'b1;
                  pend_status_in = hufdec_pkg::STS_BADCODE;
                  pend_sym_in    = '0;
                  state_in       = hufdec_pkg::ST_FLUSH;
               end else begin
                  if (bit_c) begin
                     mem_wd[RIGHT_LO +: IW] = next_free_ff[IW-1:0];
                  end else begin
                     mem_wd[LEFT_LO +: IW] = next_free_ff[IW-1:0];
                  end
                  next_free_in = next_free_ff + (IW+1)'(1);
                  cur_in       = next_free_ff[IW-1:0];
                  fresh_in     = 1'b1;
                  cnt_in       = cnt_ff - 6'd1;
                  bits_in      = {bits_ff[hufdec_pkg::CODE_W-2:0], 1'b0};
                  state_in     = hufdec_pkg::ST_ADD_EV;
               end
            end else begin
               cur_in   = slot;
               fresh_in = 1'b0;
               cnt_in   = cnt_ff - 6'd1;
               bits_in  = {bits_ff[hufdec_pkg::CODE_W-2:0], 1'b0};
               state_in = hufdec_pkg::ST_ADD_RD;
            end
         end
         hufdec_pkg::ST_DEC_RD: begin
            rd_en    = 1'b1;
            state_in = hufdec_pkg::ST_DEC_EV;
         end
         hufdec_pkg::ST_DEC_EV: begin
            if (!check_ff) begin
               if (slot == '0) begin
                  emit        = 1'b1;
                  emit_status = hufdec_pkg::STS_MISSING;
               end else begin
                  // Fetch the child to see whether it is a leaf
                  cur_in   = slot;
                  check_in = 1'b1;
                  state_in = hufdec_pkg::ST_DEC_RD;
               end
            end else if (ent_left == '0 && ent_right == '0) begin
               emit        = 1'b1;
               emit_status = hufdec_pkg::STS_SYMBOL;
               emit_sym    = ent[SYM_LO +: hufdec_pkg::SYM_W];
            end else begin
               // Inner node: stay here, its entry is already in hand
               walk_in  = cur_ff;
               check_in = 1'b0;
               cnt_in   = cnt_ff - 6'd1;
               bits_in  = {bits_ff[hufdec_pkg::CODE_W-2:0], 1'b0};
               if (cnt_ff == 6'd1) begin
                  state_in = pend_valid_ff ? hufdec_pkg::ST_FLUSH : hufdec_pkg::ST_IDLE;
               end else begin
                  state_in = hufdec_pkg::ST_DEC_EV;
               end
            end
            // Hold the step while the output register cannot take the held result
            stall = emit && pend_valid_ff && !out_free;
            if (emit && !stall) begin
               walk_in  = '0;
               cur_in   = '0;
               check_in = 1'b0;
               cnt_in   = cnt_ff - 6'd1;
               bits_in  = {bits_ff[hufdec_pkg::CODE_W-2:0], 1'b0};
               if (cnt_ff == 6'd1) begin
                  state_in = hufdec_pkg::ST_FLUSH;
               end else begin
                  state_in = hufdec_pkg::ST_DEC_RD;
               end
            end
         end
         hufdec_pkg::ST_FLUSH: begin
            // Send the held result as the last of the transaction
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_sym_in    = pend_sym_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = hufdec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hufdec_pkg::ST_IDLE;
         end
      endcase

      // Push a new result through the holding register
      if (emit && !stall) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = pend_status_ff;
            rsp_sym_in    = pend_sym_ff;
            rsp_last_in   = 1'b0;
         end
         pend_valid_in  = 1'b1;
         pend_status_in = emit_status;
         pend_sym_in    = emit_sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hufdec_pkg::ST_INIT;
         next_free_ff  <= (IW+1)'(1);
         walk_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fresh_ff      <= 1'b0;
         check_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_free_ff  <= next_free_in;
         walk_ff       <= walk_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fresh_ff      <= fresh_in;
         check_ff      <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      cnt_ff         <= cnt_in;
      bits_ff        <= bits_in;
      sym_ff         <= sym_in;
      pend_status_ff <= pend_status_in;
      pend_sym_ff    <= pend_sym_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_sym_ff     <= rsp_sym_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_sym_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A new transaction never finds a result still held back
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("result still held while taking a new transaction");

   // The flush state always has a held result to send
   a_flush_has_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hufdec_pkg::ST_FLUSH) |-> pend_valid_ff)
      else $error("flush without a held result");

   // Allocation count stays within the table and never drops below the root
   a_next_free_range: assert property (@(posedge clock) disable iff (reset)
      (next_free_ff != '0) && (next_free_ff <= (IW+1)'(NODE_COUNT)))
      else $error("next free node out of range");

   // A fresh node is always the one allocated last
   a_fresh_is_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hufdec_pkg::ST_ADD_EV && fresh_ff)
         |-> ({1'b0, cur_ff} == next_free_ff - (IW+1)'(1)))
      else $error("fresh node is not the latest allocation");

endmodule
